/* sv/frustum_cull_test_core_macros.svh */
// Assertion macros shared by the frustum cull checker.
// No dependencies; included by the checker file only.
`ifndef FRUSTUM_CULL_TEST_CORE_MACROS_SVH
`define FRUSTUM_CULL_TEST_CORE_MACROS_SVH

// Implication checked every clock, abandoned while reset is high.
`define FCULL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("fcull assertion failed");

// Next-cycle implication that is also checked during reset.
`define FCULL_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("fcull assertion failed");

`endif

/* sv/fcull_pkg.sv */
// Package for the frustum cull test core: query word type, op codes, widths.
// No dependencies; used by every module of the block.
package fcull_pkg;

   localparam int COORD_W         = 16;
   localparam int RADIUS_W        = 15;
   localparam int PLANE_W         = 64;
   localparam int PROD_W          = 32;
   localparam int BIAS_W          = 31;
   localparam int DIST_W          = 36;
   localparam int FRAC_SHIFT      = 14;
   localparam int REG_COUNT       = 6;
   localparam int REG_IDX_W       = 3;
   localparam int CSR_ADDR_W      = 6;
   localparam int PLANE_COUNT_DEF = 6;

   typedef enum logic [1:0] {
      OP_POINT  = 2'd0,
      OP_SPHERE = 2'd1,
      OP_BOX    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // One query as it travels along the row of plane cells.
   typedef struct packed {
      logic                valid;
      logic [1:0]          op;
      logic [COORD_W-1:0]  pos_x;
      logic [COORD_W-1:0]  pos_y;
      logic [COORD_W-1:0]  pos_z;
      logic [COORD_W-1:0]  max_x;
      logic [COORD_W-1:0]  max_y;
      logic [COORD_W-1:0]  max_z;
      logic [RADIUS_W-1:0] radius;
      logic                in_view;
   } query_type;

endpackage

/* sv/fcull_csr.sv */
// APB-style register file holding the six packed plane registers.
// Depends on fcull_pkg.
module fcull_csr import fcull_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [PLANE_W-1:0]    pwdata,
   output logic [PLANE_W-1:0]    prdata,
   output logic                  pready,
   output logic [PLANE_W-1:0]    planes [REG_COUNT]
);

   logic [PLANE_W-1:0]   plane_ff [REG_COUNT];
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 idx_ok;
   logic                 wr_en;

   // Registers sit on 8-byte boundaries.
   assign reg_idx = paddr[CSR_ADDR_W-1:3];
   assign idx_ok  = (reg_idx < REG_IDX_W'(REG_COUNT));
   assign wr_en   = psel && penable && pwrite && idx_ok;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (wr_en) begin
         plane_ff[reg_idx] <= pwdata;
      end
   end

   always_comb begin
      prdata = '0;
      if (idx_ok) begin
         prdata = plane_ff[reg_idx];
      end
   end

   assign planes = plane_ff;

endmodule

/* sv/fcull_cell.sv */
// One plane cell: two register stages that test the passing query
// against a single plane and fold the verdict into its in_view flag.
// Depends on fcull_pkg.
module fcull_cell import fcull_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [PLANE_W-1:0] plane,
   input  query_type          query_in,
   output query_type          query_out
);

   logic signed [COORD_W-1:0] nx, ny, nz, dofs;
   logic                      is_box, is_sphere;
   logic [COORD_W-1:0]        vx, vy, vz;

   query_type                 qa_in, qa_ff;
   logic signed [PROD_W-1:0]  prod_x_in, prod_y_in, prod_z_in;
   logic signed [PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [BIAS_W-1:0]  bias_in, bias_ff;

   logic signed [DIST_W-1:0]  dist_sum;
   logic                      tested;
   query_type                 qb_in, qb_ff;

   assign nx   = $signed(plane[15:0]);
   assign ny   = $signed(plane[31:16]);
   assign nz   = $signed(plane[47:32]);
   assign dofs = $signed(plane[63:48]);

   assign is_box    = (query_in.op == OP_BOX);
   assign is_sphere = (query_in.op == OP_SPHERE);

   // For a box the p-vertex takes the max corner where the normal is not negative.
   assign vx = (is_box && !nx[COORD_W-1]) ? query_in.max_x : query_in.pos_x;
   assign vy = (is_box && !ny[COORD_W-1]) ? query_in.max_y : query_in.pos_y;
   assign vz = (is_box && !nz[COORD_W-1]) ? query_in.max_z : query_in.pos_z;

   always_comb begin
      qa_in     = query_in;
      prod_x_in = nx * $signed(vx);
      prod_y_in = ny * $signed(vy);
      prod_z_in = nz * $signed(vz);
      // The sphere radius moves the rejection threshold, so it joins the offset.
      bias_in   = $signed({dofs[COORD_W-1], dofs, {FRAC_SHIFT{1'b0}}})
                + (is_sphere ? $signed({2'b00, query_in.radius, {FRAC_SHIFT{1'b0}}})
                             : BIAS_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff.valid <= 1'b0;
      end else begin
         qa_ff     <= qa_in;
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         bias_ff   <= bias_in;
      end
   end

   always_comb begin
      dist_sum = DIST_W'(prod_x_ff) + DIST_W'(prod_y_ff)
               + DIST_W'(prod_z_ff) + DIST_W'(bias_ff);
      tested = (qa_ff.op == OP_POINT) || (qa_ff.op == OP_SPHERE) || (qa_ff.op == OP_BOX);
      qb_in         = qa_ff;
      qb_in.in_view = qa_ff.in_view && !(tested && dist_sum[DIST_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qb_ff.valid <= 1'b0;
      end else begin
         qb_ff <= qb_in;
      end
   end

   assign query_out = qb_ff;

endmodule

/* sv/frustum_cull_test_core.sv */
// Frustum cull test core: a point, sphere or box query is tested against the planes.
// Path: each query passes two register stages per plane cell in the row, one cell per
// plane, before the result strobe and verdict appear on the response ports.
// Throughput: one query per cycle; busy stays low and results cannot be stalled.
// Reset: synchronous, clears the plane registers to zero and drops queries in flight.
// Depends on fcull_pkg, fcull_csr and fcull_cell.
module frustum_cull_test_core import fcull_pkg::*; #(
   parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_op,
   input  logic [COORD_W-1:0]    req_pos_x,
   input  logic [COORD_W-1:0]    req_pos_y,
   input  logic [COORD_W-1:0]    req_pos_z,
   input  logic [COORD_W-1:0]    req_max_x,
   input  logic [COORD_W-1:0]    req_max_y,
   input  logic [COORD_W-1:0]    req_max_z,
   input  logic [RADIUS_W-1:0]   req_radius,
   output logic                  rsp_valid,
   output logic                  rsp_inside_res,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [PLANE_W-1:0]    pwdata,
   output logic [PLANE_W-1:0]    prdata,
   output logic                  pready
);

   logic [PLANE_W-1:0] planes [REG_COUNT];
   query_type          link [PLANE_COUNT+1];

   fcull_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .planes  (planes)
   );

   assign busy = 1'b0;

   always_comb begin
      link[0].valid   = start && !busy;
      link[0].op      = req_op;
      link[0].pos_x   = req_pos_x;
      link[0].pos_y   = req_pos_y;
      link[0].pos_z   = req_pos_z;
      link[0].max_x   = req_max_x;
      link[0].max_y   = req_max_y;
      link[0].max_z   = req_max_z;
      link[0].radius  = req_radius;
      link[0].in_view = 1'b1;
   end

   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
      fcull_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .plane     (planes[i]),
         .query_in  (link[i]),
         .query_out (link[i+1])
      );
   end

   assign rsp_valid      = link[PLANE_COUNT].valid;
   assign rsp_inside_res = link[PLANE_COUNT].in_view;

endmodule

/* sv/fcull_checker.sv */
// Port-level checks for the frustum cull test core, with its bind.
// Depends on fcull_pkg, frustum_cull_test_core_macros.svh and the top level's ports.
`include "frustum_cull_test_core_macros.svh"

module fcull_checker import fcull_pkg::*; #(
   parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   localparam int LAT = 2 * PLANE_COUNT;

   // The row never stalls, so busy must stay low.
   `FCULL_ASSERT_IMPLY(a_never_busy, clock, reset, 1'b1, !busy)
   // Every accepted word yields a result once it has passed through every cell of the row.
   `FCULL_ASSERT_IMPLY(a_result_follows, clock, reset, start && !busy, ##LAT rsp_valid)
   // No result appears without a word accepted at the matching edge.
   `FCULL_ASSERT_IMPLY(a_no_phantom, clock, reset, rsp_valid, $past(start && !busy, LAT))
   // Reset flushes the row.
   `FCULL_ASSERT_NEXT(a_reset_flush, clock, reset, !rsp_valid)

endmodule

bind frustum_cull_test_core fcull_checker #(.PLANE_COUNT(PLANE_COUNT)) u_fcull_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

/* bench/frustum_cull_test_core_test.sv */
// Self-checking bench for frustum_cull_test_core: point, sphere and box queries
// against several plane settings loaded over the APB port. Depends on fcull_pkg.
module frustum_cull_test_core_test;
   import fcull_pkg::*;

   localparam int              PLANE_ADDR_STEP = 8;
   localparam int              DRAIN_CYCLES    = 2 * PLANE_COUNT_DEF + 4;
   localparam logic [15:0]     UNIT_NORMAL     = 16'sd16384;

   typedef struct {
      op_type             op;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic signed [15:0] max_x;
      logic signed [15:0] max_y;
      logic signed [15:0] max_z;
      logic [14:0]        radius;
   } cull_query_type;

   logic                  clock;
   logic                  reset   = 1'b1;
   logic                  start   = 1'b0;
   logic                  busy;
   logic [1:0]            req_op     = OP_POINT;
   logic [COORD_W-1:0]    req_pos_x  = '0;
   logic [COORD_W-1:0]    req_pos_y  = '0;
   logic [COORD_W-1:0]    req_pos_z  = '0;
   logic [COORD_W-1:0]    req_max_x  = '0;
   logic [COORD_W-1:0]    req_max_y  = '0;
   logic [COORD_W-1:0]    req_max_z  = '0;
   logic [RADIUS_W-1:0]   req_radius = '0;
   logic                  rsp_valid;
   logic                  rsp_inside_res;
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [PLANE_W-1:0]    pwdata  = '0;
   logic [PLANE_W-1:0]    prdata;
   logic                  pready;

   cull_query_type    query_backlog[$];
   bit                expected_inside[$];
   logic [PLANE_W-1:0] plane_copy[REG_COUNT];
   int                mismatch_count = 0;
   bit                req_taken      = 1'b0;
   bit                calm           = 1'b0;
   int                idle_left      = 0;

   frustum_cull_test_core #(.PLANE_COUNT(PLANE_COUNT_DEF)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .req_max_x(req_max_x), .req_max_y(req_max_y),
      .req_max_z(req_max_z), .req_radius(req_radius),
      .rsp_valid(rsp_valid), .rsp_inside_res(rsp_inside_res),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Expected verdict of one query against the planes currently loaded.
   function automatic bit query_inside(cull_query_type q);
      logic signed [15:0] nx, ny, nz, d;
      logic signed [15:0] vx, vy, vz;
      longint             dist_val;
      bit                 verdict;
      verdict = 1'b1;
      if (q.op != OP_NONE) begin
         for (int i = 0; i < PLANE_COUNT_DEF; i++) begin
            {d, nz, ny, nx} = plane_copy[i];
            if (q.op == OP_BOX) begin
               // The box corner farthest along the normal decides.
               vx = (nx < 0) ? q.pos_x : q.max_x;
               vy = (ny < 0) ? q.pos_y : q.max_y;
               vz = (nz < 0) ? q.pos_z : q.max_z;
            end else begin
               vx = q.pos_x;
               vy = q.pos_y;
               vz = q.pos_z;
            end
            dist_val = longint'(nx) * longint'(vx) + longint'(ny) * longint'(vy)
                     + longint'(nz) * longint'(vz) + (longint'(d) <<< FRAC_SHIFT);
            if (q.op == OP_SPHERE) begin
               if (dist_val < -(longint'(q.radius) <<< FRAC_SHIFT)) verdict = 1'b0;
            end else if (dist_val < 0) begin
               verdict = 1'b0;
            end
         end
      end
      return verdict;
   endfunction

   function automatic logic [63:0] pack_plane(int nx, int ny, int nz, int d);
      return {d[15:0], nz[15:0], ny[15:0], nx[15:0]};
   endfunction

   function automatic void push_query(op_type op, int px, int py, int pz,
                                      int mx, int my, int mz, int rad);
      cull_query_type q;
      q.op     = op;
      q.pos_x  = px[15:0];
      q.pos_y  = py[15:0];
      q.pos_z  = pz[15:0];
      q.max_x  = mx[15:0];
      q.max_y  = my[15:0];
      q.max_z  = mz[15:0];
      q.radius = rad[14:0];
      query_backlog.push_back(q);
   endfunction

   // Mostly values near the region of interest, now and then the full range.
   function automatic logic signed [15:0] pick_coord(int span);
      int v;
      if ($urandom_range(0, 3) == 0) begin
         v = int'($urandom);
      end else begin
         v = int'($urandom_range(0, 2 * span)) - span;
      end
      return v[15:0];
   endfunction

   function automatic void queue_random_queries(int count, int span);
      cull_query_type     q;
      logic signed [15:0] lo, hi;
      int                 pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         q.op = (pick < 3) ? OP_POINT : (pick < 6) ? OP_SPHERE :
                (pick < 9) ? OP_BOX : OP_NONE;
         q.pos_x  = pick_coord(span);
         q.pos_y  = pick_coord(span);
         q.pos_z  = pick_coord(span);
         q.max_x  = pick_coord(span);
         q.max_y  = pick_coord(span);
         q.max_z  = pick_coord(span);
         q.radius = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                 : 15'($urandom_range(0, span));
         // Most boxes are well formed; the rest keep inverted corners.
         if ($urandom_range(0, 4) != 0) begin
            lo = q.pos_x; hi = q.max_x;
            if (hi < lo) begin q.pos_x = hi; q.max_x = lo; end
            lo = q.pos_y; hi = q.max_y;
            if (hi < lo) begin q.pos_y = hi; q.max_y = lo; end
            lo = q.pos_z; hi = q.max_z;
            if (hi < lo) begin q.pos_z = hi; q.max_z = lo; end
         end
         query_backlog.push_back(q);
      end
   endfunction

   task automatic write_plane(int idx, logic [63:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx * PLANE_ADDR_STEP);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      plane_copy[idx] = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // An axis-aligned cube of half size half around the origin.
   task automatic load_axis_box(int half);
      write_plane(0, pack_plane(UNIT_NORMAL, 0, 0, half));
      write_plane(1, pack_plane(-UNIT_NORMAL, 0, 0, half));
      write_plane(2, pack_plane(0, UNIT_NORMAL, 0, half));
      write_plane(3, pack_plane(0, -UNIT_NORMAL, 0, half));
      write_plane(4, pack_plane(0, 0, UNIT_NORMAL, half));
      write_plane(5, pack_plane(0, 0, -UNIT_NORMAL, half));
   endtask

   task automatic wait_for_quiet();
      while (query_backlog.size() != 0 || start || expected_inside.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Driver: presents the next word once the previous one has been taken.
   always @(negedge clock) begin
      cull_query_type q;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (query_backlog.size() != 0 && !calm && $urandom_range(0, 19) == 0) begin
            idle_left = $urandom_range(1, 14) - 1;
            start <= 1'b0;
         end else if (query_backlog.size() != 0) begin
            q = query_backlog.pop_front();
            start      <= 1'b1;
            req_op     <= q.op;
            req_pos_x  <= q.pos_x;
            req_pos_y  <= q.pos_y;
            req_pos_z  <= q.pos_z;
            req_max_x  <= q.max_x;
            req_max_y  <= q.max_y;
            req_max_z  <= q.max_z;
            req_radius <= q.radius;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks result words, then predicts for the word taken at this edge.
   always @(posedge clock) begin
      cull_query_type q;
      bit             want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_inside.size() == 0) begin
               $display("%0t: inside_res %0b with no query outstanding", $time,
                        rsp_inside_res);
               mismatch_count++;
            end else begin
               want = expected_inside.pop_front();
               if (rsp_inside_res !== want) begin
                  $display("%0t: inside_res expected %0b actual %0b", $time, want,
                           rsp_inside_res);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            q.op     = op_type'(req_op);
            q.pos_x  = req_pos_x;
            q.pos_y  = req_pos_y;
            q.pos_z  = req_pos_z;
            q.max_x  = req_max_x;
            q.max_y  = req_max_y;
            q.max_z  = req_max_z;
            q.radius = req_radius;
            expected_inside.push_back(query_inside(q));
         end
         req_taken <= start && !busy;
      end
   end

   initial begin
      for (int i = 0; i < REG_COUNT; i++) plane_copy[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Planes straight out of reset accept everything.
      push_query(OP_POINT, -32768, -32768, -32768, 0, 0, 0, 0);
      push_query(OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767);
      push_query(OP_NONE, 5, -5, 5, 0, 0, 0, 0);
      queue_random_queries(100, 32767);
      wait_for_quiet();

      load_axis_box(160);
      push_query(OP_POINT, 0, 0, 0, 0, 0, 0, 0);
      push_query(OP_POINT, -160, 160, -160, 0, 0, 0, 0);
      push_query(OP_POINT, -161, 0, 0, 0, 0, 0, 0);
      push_query(OP_POINT, 0, 161, 0, 0, 0, 0, 0);
      push_query(OP_POINT, 32767, 32767, 32767, 0, 0, 0, 0);
      push_query(OP_SPHERE, -170, 0, 0, 0, 0, 0, 10);
      push_query(OP_SPHERE, -171, 0, 0, 0, 0, 0, 10);
      push_query(OP_SPHERE, 0, 0, 32767, 0, 0, 0, 32767);
      push_query(OP_SPHERE, 0, 0, -32768, 0, 0, 0, 0);
      push_query(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0);
      push_query(OP_BOX, 170, 0, 0, 200, 10, 10, 0);
      // Inverted corners go through the corner rule without swapping.
      push_query(OP_BOX, 100, 100, 100, -100, -100, -100, 0);
      push_query(OP_BOX, 300, 300, 300, -300, -300, -300, 0);
      push_query(OP_NONE, 32767, -32768, 32767, 0, 0, 0, 0);
      queue_random_queries(400, 320);
      wait_for_quiet();

      // Tilted planes that all keep the origin inside.
      for (int i = 0; i < REG_COUNT; i++)
         write_plane(i, pack_plane(int'($urandom_range(0, 32768)) - 16384,
                                   int'($urandom_range(0, 32768)) - 16384,
                                   int'($urandom_range(0, 32768)) - 16384,
                                   $urandom_range(0, 2000)));
      queue_random_queries(500, 4000);
      wait_for_quiet();

      for (int i = 0; i < REG_COUNT; i++) write_plane(i, {$urandom, $urandom});
      queue_random_queries(400, 32767);
      wait_for_quiet();

      write_plane(0, pack_plane(-32768, -32768, -32768, -32768));
      for (int i = 1; i < REG_COUNT; i++)
         write_plane(i, pack_plane(32767, 32767, 32767, 32767));
      push_query(OP_POINT, -32768, -32768, -32768, 0, 0, 0, 0);
      push_query(OP_POINT, 32767, 32767, 32767, 0, 0, 0, 0);
      push_query(OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767);
      push_query(OP_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0);
      queue_random_queries(200, 32767);
      wait_for_quiet();

      // A zero normal with a negative offset rejects all point, box and zero-radius sphere queries.
      write_plane(2, pack_plane(0, 0, 0, -1));
      push_query(OP_SPHERE, 0, 0, 0, 0, 0, 0, 32767);
      push_query(OP_NONE, 0, 0, 0, 0, 0, 0, 0);
      queue_random_queries(50, 32767);
      wait_for_quiet();

      load_axis_box(480);
      calm = 1'b1;
      queue_random_queries(400, 960);
      wait_for_quiet();

      if (mismatch_count == 0 && expected_inside.size() == 0) begin
         $display("[frustum_cull_test_core] OK");
      end else begin
         $display("[frustum_cull_test_core] ERROR");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("[frustum_cull_test_core] ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/fcull_pkg.sv
sv/fcull_csr.sv
sv/fcull_cell.sv
sv/frustum_cull_test_core.sv
sv/fcull_checker.sv
bench/frustum_cull_test_core_test.sv
